/* src/porter_duff_pixel_blender_top_defines.svh */
// assertion macros for the porter-duff pixel blender
`ifndef PORTER_DUFF_PIXEL_BLENDER_TOP_DEFINES_SVH
`define PORTER_DUFF_PIXEL_BLENDER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// condition in this cycle implies a consequence in the same cycle
`define PDB_ASSERT_SAME(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// condition in this cycle implies a consequence in the next cycle
`define PDB_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define PDB_ASSERT_SAME(label, clk, rst, cond, cons)
`define PDB_ASSERT_NEXT(label, clk, rst, cond, cons)

`endif

`endif

/* src/pdb_pkg.sv */
// shared types, codes and factor decode for the porter-duff pixel blender
`timescale 1ns / 1ps
package pdb_pkg;

   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned MODE_W   = 4;
   localparam int unsigned NUM_CHAN = 4;

   // blend mode register codes
   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR    = 4'd0,
      MODE_SRC      = 4'd1,
      MODE_DST      = 4'd2,
      MODE_SRC_OVER = 4'd3,
      MODE_DST_OVER = 4'd4,
      MODE_SRC_IN   = 4'd5,
      MODE_DST_IN   = 4'd6,
      MODE_SRC_OUT  = 4'd7,
      MODE_DST_OUT  = 4'd8,
      MODE_SRC_ATOP = 4'd9,
      MODE_DST_ATOP = 4'd10,
      MODE_XOR      = 4'd11
   } mode_type;

   // blend factor selectors
   typedef enum logic [2:0] {
      FAC_ZERO   = 3'd0,
      FAC_ONE    = 3'd1,
      FAC_DA     = 3'd2,
      FAC_INV_DA = 3'd3,
      FAC_SA     = 3'd4,
      FAC_INV_SA = 3'd5
   } fac_type;

   // per-stage load enables from the pipeline control
   typedef struct packed {
      logic ld2;
      logic ld3;
      logic ld4;
   } adv_type;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

   // source factor for a mode; unknown codes blend as src_over
   function automatic fac_type src_fac(input mode_type mode);
      fac_type f;
      case (mode)
         MODE_CLEAR:    f = FAC_ZERO;
         MODE_SRC:      f = FAC_ONE;
         MODE_DST:      f = FAC_ZERO;
         MODE_SRC_OVER: f = FAC_ONE;
         MODE_DST_OVER: f = FAC_INV_DA;
         MODE_SRC_IN:   f = FAC_DA;
         MODE_DST_IN:   f = FAC_ZERO;
         MODE_SRC_OUT:  f = FAC_INV_DA;
         MODE_DST_OUT:  f = FAC_ZERO;
         MODE_SRC_ATOP: f = FAC_DA;
         MODE_DST_ATOP: f = FAC_INV_DA;
         MODE_XOR:      f = FAC_INV_DA;
         default:       f = FAC_ONE;
      endcase
      return f;
   endfunction

   // destination factor for a mode; unknown codes blend as src_over
   function automatic fac_type dst_fac(input mode_type mode);
      fac_type f;
      case (mode)
         MODE_CLEAR:    f = FAC_ZERO;
         MODE_SRC:      f = FAC_ZERO;
         MODE_DST:      f = FAC_ONE;
         MODE_SRC_OVER: f = FAC_INV_SA;
         MODE_DST_OVER: f = FAC_ONE;
         MODE_SRC_IN:   f = FAC_ZERO;
         MODE_DST_IN:   f = FAC_SA;
         MODE_SRC_OUT:  f = FAC_ZERO;
         MODE_DST_OUT:  f = FAC_INV_SA;
         MODE_SRC_ATOP: f = FAC_INV_SA;
         MODE_DST_ATOP: f = FAC_SA;
         MODE_XOR:      f = FAC_INV_SA;
         default:       f = FAC_INV_SA;
      endcase
      return f;
   endfunction

   // factor value from its selector and the two alphas
   function automatic logic [CHAN_W-1:0] fac_value(input fac_type code,
                                                   input logic [CHAN_W-1:0] sa,
                                                   input logic [CHAN_W-1:0] da);
      logic [CHAN_W-1:0] v;
      case (code)
         FAC_ONE:    v = CHAN_MAX;
         FAC_DA:     v = da;
         FAC_INV_DA: v = CHAN_MAX - da;
         FAC_SA:     v = sa;
         FAC_INV_SA: v = CHAN_MAX - sa;
         default:    v = '0;
      endcase
      return v;
   endfunction

endpackage

/* src/pdb_chan.sv */
// one channel datapath: multiply, rounded divide by 255, sum and clamp
`timescale 1ns / 1ps
module pdb_chan (
   input  logic                   clock,
   input  pdb_pkg::adv_type       adv,
   input  logic [7:0]             src_val,
   input  logic [7:0]             dst_val,
   input  logic [7:0]             src_fac,
   input  logic [7:0]             dst_fac,
   output logic [7:0]             out_val
);
   import pdb_pkg::*;

   localparam int unsigned PROD_W = 2 * CHAN_W;
   localparam int unsigned DIV_W  = PROD_W + 9;

   // round(x / 255) as ((x + 128) * 257) >> 16, with the multiply as shift and add
   function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
      logic [DIV_W-1:0] y;
      logic [DIV_W-1:0] p;
      y = DIV_W'(x) + DIV_W'(128);
      p = (y << 8) + y;
      return p[PROD_W +: CHAN_W];
   endfunction

   logic [PROD_W-1:0] prod_s_ff, prod_s_in;
   logic [PROD_W-1:0] prod_d_ff, prod_d_in;
   logic [CHAN_W-1:0] quo_s_ff, quo_s_in;
   logic [CHAN_W-1:0] quo_d_ff, quo_d_in;
   logic [CHAN_W-1:0] out_ff, out_in;
   logic [CHAN_W:0]   sum;

   // stage 2: products
   assign prod_s_in = PROD_W'(src_val) * PROD_W'(src_fac);
   assign prod_d_in = PROD_W'(dst_val) * PROD_W'(dst_fac);

   // stage 3: rounded quotients
   assign quo_s_in = div255(prod_s_ff);
   assign quo_d_in = div255(prod_d_ff);

   // stage 4: sum with clamp for badly premultiplied input
   assign sum    = {1'b0, quo_s_ff} + {1'b0, quo_d_ff};
   assign out_in = sum[CHAN_W] ? CHAN_MAX : sum[CHAN_W-1:0];

   always_ff @(posedge clock) begin
      if (adv.ld2) begin
         prod_s_ff <= prod_s_in;
         prod_d_ff <= prod_d_in;
      end
      if (adv.ld3) begin
         quo_s_ff <= quo_s_in;
         quo_d_ff <= quo_d_in;
      end
      if (adv.ld4) begin
         out_ff <= out_in;
      end
   end

   assign out_val = out_ff;

endmodule

/* src/porter_duff_pixel_blender_top.sv */
// an accepted item reaches rsp_valid through the stage registers in order
// throughput: one item per cycle while rsp_stall is low; four register stages
//   (decode, multiply, divide by 255, sum and clamp); each holds while the next holds
// reset: clears all stage valid bits and sets blend_mode to src_over
// req_stall rises only when all four stages hold items and rsp_stall is high
`timescale 1ns / 1ps
`include "porter_duff_pixel_blender_top_defines.svh"
module porter_duff_pixel_blender_top (
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_wr_en,
   input  logic [3:0] csr_wr_data,
   // input pixels
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_src_alpha,
   input  logic [7:0] req_src_red,
   input  logic [7:0] req_src_green,
   input  logic [7:0] req_src_blue,
   input  logic [7:0] req_dst_alpha,
   input  logic [7:0] req_dst_red,
   input  logic [7:0] req_dst_green,
   input  logic [7:0] req_dst_blue,
   // blended pixels
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_alpha,
   output logic [7:0] rsp_out_red,
   output logic [7:0] rsp_out_green,
   output logic [7:0] rsp_out_blue
);
   import pdb_pkg::*;

   mode_type          mode_ff, mode_in;
   logic              v1_ff, v2_ff, v3_ff, v4_ff;
   logic              rdy1, rdy2, rdy3, rdy4;
   logic              ld1;
   adv_type           adv;
   logic [CHAN_W-1:0] src_ff [NUM_CHAN];
   logic [CHAN_W-1:0] dst_ff [NUM_CHAN];
   logic [CHAN_W-1:0] fs_ff, fs_in;
   logic [CHAN_W-1:0] fd_ff, fd_in;
   logic [CHAN_W-1:0] res [NUM_CHAN];

   // blend mode register
   assign mode_in = csr_wr_en ? mode_type'(csr_wr_data) : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SRC_OVER;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // stage readiness, back to front
   assign rdy4      = !v4_ff || !rsp_stall;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_stall = !rdy1;

   assign ld1     = rdy1 && req_valid;
   assign adv.ld2 = rdy2 && v1_ff;
   assign adv.ld3 = rdy3 && v2_ff;
   assign adv.ld4 = rdy4 && v3_ff;

   // valid bits travel with the item
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // stage 1: factor decode and input capture
   assign fs_in = fac_value(src_fac(mode_ff), req_src_alpha, req_dst_alpha);
   assign fd_in = fac_value(dst_fac(mode_ff), req_src_alpha, req_dst_alpha);

   always_ff @(posedge clock) begin
      if (ld1) begin
         src_ff[0] <= req_src_alpha;
         src_ff[1] <= req_src_red;
         src_ff[2] <= req_src_green;
         src_ff[3] <= req_src_blue;
         dst_ff[0] <= req_dst_alpha;
         dst_ff[1] <= req_dst_red;
         dst_ff[2] <= req_dst_green;
         dst_ff[3] <= req_dst_blue;
         fs_ff     <= fs_in;
         fd_ff     <= fd_in;
      end
   end

   // stages 2 to 4, one lane per channel
   for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
      pdb_chan u_chan (
         .clock   (clock),
         .adv     (adv),
         .src_val (src_ff[c]),
         .dst_val (dst_ff[c]),
         .src_fac (fs_ff),
         .dst_fac (fd_ff),
         .out_val (res[c])
      );
   end

   assign rsp_valid     = v4_ff;
   assign rsp_out_alpha = res[0];
   assign rsp_out_red   = res[1];
   assign rsp_out_green = res[2];
   assign rsp_out_blue  = res[3];

   // checks
   `PDB_ASSERT_SAME(a_stall_only_full, clock, reset, req_stall, v1_ff && v2_ff && v3_ff && v4_ff && rsp_stall)
   `PDB_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && !req_stall, v1_ff)
   `PDB_ASSERT_NEXT(a_flow_to_out, clock, reset, v3_ff && !rsp_stall, rsp_valid)

endmodule
